// ===== rtl/core/mre_pkg.sv =====
package mre_pkg;

  localparam logic [10:0] BEACON_FRAME_LEN = 11'd13;
  localparam logic [15:0] SEQ_HALF         = 16'h7fff;

  localparam logic [1:0] CFG_OWN_NODE_ID     = 2'd0;
  localparam logic [1:0] CFG_ROOT_TIMEOUT    = 2'd1;
  localparam logic [1:0] CFG_BEACON_INTERVAL = 2'd2;

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_BEACON = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_RELAY = 2'd1,
    ACT_OWN   = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    VERD_OK        = 3'd0,
    VERD_BAD_LEN   = 3'd1,
    VERD_OWN_ID    = 3'd2,
    VERD_SEEN      = 3'd3,
    VERD_LOWER_ID  = 3'd4,
    VERD_LONGER    = 3'd5,
    VERD_STALE     = 3'd6
  } verdict_t;

  typedef struct packed {
    logic [31:0] own_node_id;
    logic [7:0]  root_timeout_secs;
    logic [7:0]  beacon_interval_secs;
  } cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [10:0] frame_length;
    logic [47:0] neighbor_addr;
    logic [31:0] beacon_root_id;
    logic [15:0] beacon_seq;
    logic [15:0] beacon_hops;
    logic [31:0] beacon_sender_id;
  } item_t;

  typedef struct packed {
    logic [31:0] seconds_now;
    logic        root_is_self;
    logic [31:0] foreign_root_id;
    logic [15:0] root_seq;
    logic [15:0] root_hops;
    logic [31:0] root_updated_at;
    logic [47:0] root_next_hop;
    logic [31:0] last_beacon_at;
    logic        beacon_sent_once;
    logic [15:0] beacon_counter;
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  verdict;
    logic        root_timed_out;
    logic [31:0] root_id;
    logic [15:0] seq;
    logic [15:0] hops;
    logic [31:0] relay_src;
    logic [31:0] current_root;
    logic [47:0] current_next_hop;
  } result_t;

endpackage

// ===== rtl/core/mesh_root_election.sv =====
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  opcode, beacon frame fields
// out_     output     out_valid/out_stall action, verdict, beacon, current root
// cfg_     input      cfg_we             cfg_index, cfg_data (32 bits)
//
// Each item is registered on acceptance and resolved when it moves on from the input
// register, when the election state and the result register are written together; one
// item per cycle unless out_stall holds a result. out_valid follows the result register,
// so each result passes through the input register and then the result register.
// rst_n is synchronous and active low; it restores the configuration defaults and state.
// While out_stall holds a result, one more item can wait in the input register.
module mesh_root_election
  import mre_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [10:0] in_frame_length,
  input  logic [47:0] in_neighbor_addr,
  input  logic [31:0] in_beacon_root_id,
  input  logic [15:0] in_beacon_seq,
  input  logic [15:0] in_beacon_hops,
  input  logic [31:0] in_beacon_sender_id,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [2:0]  out_verdict,
  output logic        out_root_timed_out,
  output logic [31:0] out_root_id,
  output logic [15:0] out_seq,
  output logic [15:0] out_hops,
  output logic [31:0] out_sender_id,
  output logic [31:0] out_current_root,
  output logic [47:0] out_current_next_hop,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  item_t   item_r;
  logic    item_vld_r;
  result_t res_nxt;
  result_t res_r;
  logic    res_vld_r;
  logic    advance;
  logic    in_take;

  // The held item moves on when the result register is empty or being emptied.
  assign advance  = item_vld_r && (!res_vld_r || !out_stall);
  assign in_stall = item_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_node_id          <= 32'd0;
      cfg_r.root_timeout_secs    <= 8'd5;
      cfg_r.beacon_interval_secs <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_NODE_ID:     cfg_r.own_node_id          <= cfg_data;
        CFG_ROOT_TIMEOUT:    cfg_r.root_timeout_secs    <= cfg_data[7:0];
        CFG_BEACON_INTERVAL: cfg_r.beacon_interval_secs <= cfg_data[7:0];
        default:             cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_take) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.opcode           <= in_opcode;
      item_r.frame_length     <= in_frame_length;
      item_r.neighbor_addr    <= in_neighbor_addr;
      item_r.beacon_root_id   <= in_beacon_root_id;
      item_r.beacon_seq       <= in_beacon_seq;
      item_r.beacon_hops      <= in_beacon_hops;
      item_r.beacon_sender_id <= in_beacon_sender_id;
    end
  end

  mre_step u_step (
    .cfg    (cfg_r),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.seconds_now      <= 32'd0;
      st_r.root_is_self     <= 1'b1;
      st_r.foreign_root_id  <= 32'd0;
      st_r.root_seq         <= 16'd0;
      st_r.root_hops        <= 16'd0;
      st_r.root_updated_at  <= 32'd0;
      st_r.root_next_hop    <= 48'd0;
      st_r.last_beacon_at   <= 32'd0;
      st_r.beacon_sent_once <= 1'b0;
      st_r.beacon_counter   <= 16'd0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (!out_stall) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid            = res_vld_r;
  assign out_action           = res_r.action;
  assign out_verdict          = res_r.verdict;
  assign out_root_timed_out   = res_r.root_timed_out;
  assign out_root_id          = res_r.root_id;
  assign out_seq              = res_r.seq;
  assign out_hops             = res_r.hops;
  assign out_sender_id        = res_r.relay_src;
  assign out_current_root     = res_r.current_root;
  assign out_current_next_hop = res_r.current_next_hop;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (item_vld_r && res_vld_r && out_stall))
    else $error("input stalled without a blocked item");

  a_self_no_hop: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.root_is_self |-> (st_r.root_next_hop == 48'd0))
    else $error("own root holds a next-hop address");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && (res_r.action == ACT_NONE)) |->
      ((res_r.root_id == 32'd0) && (res_r.seq == 16'd0) && (res_r.hops == 16'd0) &&
       (res_r.relay_src == 32'd0)))
    else $error("beacon fields set with no broadcast");

  a_relay_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && (res_r.action == ACT_RELAY)) |->
      ((res_r.verdict == VERD_OK) && !res_r.root_timed_out))
    else $error("relay with a reject verdict or timeout");

  a_self_after_timeout: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && res_r.root_timed_out) |->
      ((res_r.current_next_hop == 48'd0) && (res_r.current_root == cfg_r.own_node_id)))
    else $error("timeout did not fall back to own root");

endmodule

// ===== rtl/core/mre_step.sv =====
module mre_step
  import mre_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  st,
  input  item_t   item,
  output state_t  st_nxt,
  output result_t res
);

  logic [31:0] sec_inc;
  logic [31:0] since_update;
  logic [31:0] since_beacon;
  logic        drop_root;
  logic        self_after_tick;
  logic        send_own;
  logic [15:0] hops_inc;
  logic [31:0] cur_root;
  logic [15:0] seq_fwd;
  logic [15:0] seq_back;
  logic        seq_newer;
  logic        accept;
  logic [2:0]  verdict;

  assign sec_inc      = st.seconds_now + 32'd1;
  assign since_update = sec_inc - st.root_updated_at;
  assign since_beacon = sec_inc - st.last_beacon_at;
  assign drop_root    = !st.root_is_self && (since_update >= {24'd0, cfg.root_timeout_secs});
  assign self_after_tick = st.root_is_self || drop_root;
  assign send_own = self_after_tick &&
                    !(st.beacon_sent_once && (since_beacon < {24'd0, cfg.beacon_interval_secs}));

  assign hops_inc = item.beacon_hops + 16'd1;
  assign cur_root = st.root_is_self ? cfg.own_node_id : st.foreign_root_id;

  // Serial sequence compare modulo 2^16, split on which side is larger.
  assign seq_back  = st.root_seq - item.beacon_seq;
  assign seq_fwd   = item.beacon_seq - st.root_seq;
  assign seq_newer = (st.root_seq >= item.beacon_seq) ? (seq_back > SEQ_HALF)
                                                      : (seq_fwd < SEQ_HALF);

  always_comb begin
    accept  = 1'b0;
    verdict = VERD_OK;
    if (item.frame_length != BEACON_FRAME_LEN) begin
      verdict = VERD_BAD_LEN;
    end else if (item.beacon_root_id == cfg.own_node_id) begin
      verdict = VERD_OWN_ID;
    end else if (item.beacon_sender_id == cfg.own_node_id) begin
      verdict = VERD_SEEN;
    end else if (item.beacon_root_id < cur_root) begin
      verdict = VERD_LOWER_ID;
    end else if (item.beacon_root_id > cur_root) begin
      accept = 1'b1;
    end else if (!seq_newer) begin
      verdict = VERD_STALE;
    end else if (hops_inc > st.root_hops) begin
      verdict = VERD_LONGER;
    end else begin
      accept = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (opcode_t'(item.opcode))
      OP_TICK: begin
        st_nxt.seconds_now = sec_inc;
        if (drop_root) begin
          st_nxt.root_is_self    = 1'b1;
          st_nxt.root_next_hop   = '0;
          st_nxt.root_seq        = '0;
          st_nxt.root_hops       = '0;
          st_nxt.root_updated_at = sec_inc;
        end
        if (send_own) begin
          st_nxt.last_beacon_at   = sec_inc;
          st_nxt.beacon_sent_once = 1'b1;
          st_nxt.beacon_counter   = st.beacon_counter + 16'd1;
          st_nxt.root_seq         = st.beacon_counter;
          st_nxt.root_updated_at  = sec_inc;
          res.action    = ACT_OWN;
          res.root_id   = cfg.own_node_id;
          res.seq       = st.beacon_counter;
          res.relay_src = cfg.own_node_id;
        end
        res.root_timed_out = drop_root;
      end
      OP_BEACON: begin
        res.verdict = verdict;
        if (accept) begin
          st_nxt.root_is_self    = 1'b0;
          st_nxt.foreign_root_id = item.beacon_root_id;
          st_nxt.root_next_hop   = item.neighbor_addr;
          st_nxt.root_hops       = hops_inc;
          st_nxt.root_seq        = item.beacon_seq;
          st_nxt.root_updated_at = st.seconds_now;
          res.action    = ACT_RELAY;
          res.root_id   = item.beacon_root_id;
          res.seq       = item.beacon_seq;
          res.hops      = hops_inc;
          res.relay_src = cfg.own_node_id;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
    res.current_root     = st_nxt.root_is_self ? cfg.own_node_id : st_nxt.foreign_root_id;
    res.current_next_hop = st_nxt.root_is_self ? 48'd0 : st_nxt.root_next_hop;
  end

endmodule
